@@ design/polynomial_curve_eval_and_inverse_unit_macros.svh @@
// Assertion macros for the polynomial curve unit.
// Uses the clk and rst names of the module that includes it.
`ifndef POLYNOMIAL_CURVE_EVAL_AND_INVERSE_UNIT_MACROS_SVH
`define POLYNOMIAL_CURVE_EVAL_AND_INVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define PCEI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCEI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pcei_pkg.sv @@
// Shared types and constants for the polynomial curve unit.
// No dependencies.
package pcei_pkg;

  localparam int DEF_MAX_TERMS    = 6;
  localparam int DEF_BISECT_STEPS = 8;
  localparam int DEF_COEFF_WIDTH  = 32;
  localparam int NUM_COEFF_REGS   = 6;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 17;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TERM_W    = 3;
  localparam int COEF_IDX_W = $clog2(NUM_COEFF_REGS);
  localparam int BND_W     = 25;   // Q0.24 bisection bounds, up to 1.0

  localparam logic [BND_W-1:0] ONE_Q24 = BND_W'(1) << 24;
  localparam int MID_RND = 128;    // half LSB when going Q0.24 -> Q0.16

  localparam logic       OP_EVAL   = 1'b0;
  localparam logic       OP_INVERT = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_NO_TERMS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0    = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIS_MID,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_EVAL_END,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;   // acc <= 0
    logic load;    // acc <= sat(coeff)
    logic mul;     // prod <= |acc| * t
    logic acc_en;  // acc <= sat(rnd(prod) + coeff)
  } mac_ctl_t;

endpackage

@@ design/pcei_cfg_regs.sv @@
// Configuration register file: term count and six Q8.24 coefficients.
// Depends on pcei_pkg.
module pcei_cfg_regs #(
  parameter int MAX_TERMS = pcei_pkg::DEF_MAX_TERMS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pcei_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcei_pkg::DATA_W-1:0]           cfg_data,
  input  logic [pcei_pkg::TERM_W-1:0]           rd_idx,
  output logic signed [pcei_pkg::DATA_W-1:0]    rd_coeff,
  output logic [pcei_pkg::TERM_W-1:0]           n_terms
);
  import pcei_pkg::*;

  localparam int LIM = (MAX_TERMS < NUM_COEFF_REGS) ? MAX_TERMS : NUM_COEFF_REGS;

  logic [TERM_W-1:0]        term_count;
  logic signed [DATA_W-1:0] coeff [NUM_COEFF_REGS];
  logic [CFG_IDX_W-1:0]     slot;

  assign cfg_ready = 1'b1;
  assign slot      = cfg_index - REG_COEFF_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
      for (int i = 0; i < NUM_COEFF_REGS; i++) coeff[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TERM_COUNT) begin
        term_count <= cfg_data[TERM_W-1:0];
      end else if (slot < CFG_IDX_W'(NUM_COEFF_REGS)) begin
        coeff[slot[COEF_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  assign n_terms = (term_count > TERM_W'(LIM)) ? TERM_W'(LIM) : term_count;

  // out-of-range index (n-1 with no terms) reads as zero
  assign rd_coeff = (rd_idx < TERM_W'(NUM_COEFF_REGS)) ? coeff[rd_idx[COEF_IDX_W-1:0]] : '0;

endmodule

@@ design/pcei_mac.sv @@
// Shared Horner multiply-add unit: registered |acc|*t product, then
// round, sign, add coefficient and saturate. Depends on pcei_pkg.
module pcei_mac #(
  parameter int COEFF_WIDTH = pcei_pkg::DEF_COEFF_WIDTH
) (
  input  logic                                clk,
  input  pcei_pkg::mac_ctl_t                  ctl,
  input  logic [pcei_pkg::POS_W-1:0]          t,
  input  logic signed [pcei_pkg::DATA_W-1:0]  coeff,
  output logic signed [COEFF_WIDTH-1:0]       acc
);
  import pcei_pkg::*;

  localparam int CW  = COEFF_WIDTH;
  localparam int PW  = CW + POS_W;
  localparam int RW  = PW + 1 - FRAC_BITS;
  localparam int SW  = ((CW + 2 > DATA_W) ? CW + 2 : DATA_W) + 1;
  localparam logic signed [SW-1:0] ACC_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic [PW:0] RND_HALF = (PW+1)'(1) << (FRAC_BITS - 1);

  logic [PW-1:0]          prod;
  logic                   neg;
  logic [CW-1:0]          acc_mag;
  logic [PW:0]            rsum;
  logic [RW-1:0]          rnd_mag;
  logic signed [SW-1:0]   term;
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   coeff_x;

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > ACC_MAX)      r = ACC_MAX[CW-1:0];
    else if (v < ACC_MIN) r = ACC_MIN[CW-1:0];
    else                  r = v[CW-1:0];
    return r;
  endfunction

  // most negative value negates to 2^(CW-1), still fits unsigned CW bits
  assign acc_mag = acc[CW-1] ? unsigned'(-acc) : unsigned'(acc);
  assign rsum    = {1'b0, prod} + RND_HALF;
  assign rnd_mag = rsum[PW:FRAC_BITS];
  assign term    = neg ? -signed'(SW'(rnd_mag)) : signed'(SW'(rnd_mag));
  assign coeff_x = SW'(coeff);
  assign sum     = term + coeff_x;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= acc_mag * PW'(t);
      neg  <= acc[CW-1];
    end
    if (ctl.clear)       acc <= '0;
    else if (ctl.load)   acc <= sat(coeff_x);
    else if (ctl.acc_en) acc <= sat(sum);
  end

endmodule

@@ design/polynomial_curve_eval_and_inverse_unit.sv @@
// Polynomial tone curve unit. Evaluates f(t) = sum coeff_i * t^i (Horner,
// saturating Q8.24) or inverts it by bisection, one item at a time through a
// single multiply-add unit; each Horner step fills its product register,
// then rounds, adds and saturates. An evaluation loads the top coefficient,
// runs a multiply and an add step per further term, then ends; a bisection
// step takes the midpoint, evaluates there and narrows the bracket, and the
// last midpoint is the result. An out-of-range target or an evaluation with
// no terms goes straight to the done state, where a result also waits while
// the previous one sits unaccepted in the output register. in_ready is high
// only while no item is in work; a finished result waits in the output
// register without blocking the next input beat.
// Depends on pcei_pkg, pcei_cfg_regs, pcei_mac and the assertion macros.
`include "polynomial_curve_eval_and_inverse_unit_macros.svh"

module polynomial_curve_eval_and_inverse_unit #(
  parameter int MAX_TERMS    = pcei_pkg::DEF_MAX_TERMS,
  parameter int BISECT_STEPS = pcei_pkg::DEF_BISECT_STEPS,
  parameter int COEFF_WIDTH  = pcei_pkg::DEF_COEFF_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [pcei_pkg::POS_W-1:0]          position,
  input  logic signed [pcei_pkg::DATA_W-1:0]  target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pcei_pkg::DATA_W-1:0]  result_value,
  output logic [1:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcei_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcei_pkg::DATA_W-1:0]         cfg_data
);
  import pcei_pkg::*;

  localparam int CW     = COEFF_WIDTH;
  localparam int EW     = (CW > DATA_W) ? CW : DATA_W;
  localparam int STEP_W = $clog2(BISECT_STEPS);

  state_t state, state_next;

  logic                     op, op_next;
  logic signed [DATA_W-1:0] tgt, tgt_next;
  logic [POS_W-1:0]         t, t_next;
  logic [BND_W-1:0]         lo, lo_next, hi, hi_next;
  logic [TERM_W-1:0]        k, k_next;
  logic [STEP_W-1:0]        step, step_next;
  logic signed [DATA_W-1:0] res, res_next;
  logic [1:0]               stat, stat_next;
  logic                     out_valid_next;
  logic                     out_load;

  logic [TERM_W-1:0]        n_terms;
  logic [TERM_W-1:0]        rd_idx;
  logic signed [DATA_W-1:0] rd_coeff;
  logic signed [CW-1:0]     acc;
  logic signed [EW-1:0]     acc_x;
  logic signed [EW-1:0]     tgt_x;
  mac_ctl_t                 ctl;

  logic [BND_W:0]           bnd_sum;
  logic [BND_W-1:0]         mid;
  logic [BND_W:0]           mid_rsum;
  logic [POS_W-1:0]         t_mid;

  pcei_cfg_regs #(.MAX_TERMS(MAX_TERMS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (rd_idx),
    .rd_coeff  (rd_coeff),
    .n_terms   (n_terms)
  );

  pcei_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac (
    .clk   (clk),
    .ctl   (ctl),
    .t     (t),
    .coeff (rd_coeff),
    .acc   (acc)
  );

  assign bnd_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = bnd_sum[BND_W:1];
  assign mid_rsum = {1'b0, mid} + (BND_W+1)'(MID_RND);
  assign t_mid    = mid_rsum[POS_W+7:8];   // Q0.24 -> Q0.16, round half up

  assign acc_x = EW'(acc);
  assign tgt_x = EW'(tgt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    tgt  <= tgt_next;
    t    <= t_next;
    lo   <= lo_next;
    hi   <= hi_next;
    k    <= k_next;
    step <= step_next;
    res  <= res_next;
    stat <= stat_next;
    if (out_load) begin
      result_value <= res;
      status       <= stat;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    tgt_next       = tgt;
    t_next         = t;
    lo_next        = lo;
    hi_next        = hi;
    k_next         = k;
    step_next      = step;
    res_next       = res;
    stat_next      = stat;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    ctl            = '0;
    rd_idx         = k - TERM_W'(1);

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next  = opcode;
          tgt_next = target;
          if (opcode == OP_INVERT) begin
            if (target < 0 || target > signed'(DATA_W'(ONE_Q24))) begin
              res_next   = '0;
              stat_next  = STAT_RANGE;
              state_next = ST_DONE;
            end else begin
              stat_next  = (n_terms == '0) ? STAT_NO_TERMS : STAT_OK;
              lo_next    = '0;
              hi_next    = ONE_Q24;
              step_next  = '0;
              state_next = ST_BIS_MID;
            end
          end else if (n_terms == '0) begin
            res_next   = '0;
            stat_next  = STAT_NO_TERMS;
            state_next = ST_DONE;
          end else begin
            t_next     = position;
            state_next = ST_LOAD;
          end
        end
      end
      ST_BIS_MID: begin
        t_next     = t_mid;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // no terms: curve reads as zero
        rd_idx     = n_terms - TERM_W'(1);
        ctl.clear  = (n_terms == '0);
        ctl.load   = 1'b1;
        k_next     = (n_terms == '0) ? '0 : n_terms - TERM_W'(1);
        state_next = (n_terms <= TERM_W'(1)) ? ST_EVAL_END : ST_MUL;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        ctl.acc_en = 1'b1;
        k_next     = k - TERM_W'(1);
        state_next = (k == TERM_W'(1)) ? ST_EVAL_END : ST_MUL;
      end
      ST_EVAL_END: begin
        if (op == OP_EVAL) begin
          res_next   = acc_x[DATA_W-1:0];
          stat_next  = STAT_OK;
          state_next = ST_DONE;
        end else begin
          if (tgt_x < acc_x) hi_next = mid;
          else               lo_next = mid;
          step_next  = step + STEP_W'(1);
          state_next = (step == STEP_W'(BISECT_STEPS - 1)) ? ST_FIN : ST_BIS_MID;
        end
      end
      ST_FIN: begin
        res_next   = DATA_W'(mid);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PCEI_ASSERT_IMP(a_bracket_ordered, state == ST_BIS_MID, (lo < hi) && (hi <= ONE_Q24), "bisection bounds out of order")
  `PCEI_ASSERT_NXT(a_beat_starts_work, in_valid && in_ready, state != ST_IDLE, "accepted beat did not start work")
  `PCEI_ASSERT_IMP(a_horner_has_term, state == ST_MUL || state == ST_ADD, k != '0, "Horner step with no term left")
  `PCEI_ASSERT_NXT(a_out_from_done, !out_valid && state != ST_DONE, !out_valid, "result raised outside done state")

endmodule
